// ----- sv/css_pkg.sv -----
// ----------------------------------------------------------------------------
// css_pkg
// Shared widths, constants and the job record handed from the accumulating
// front end to the similarity back end.
// ----------------------------------------------------------------------------
package css_pkg;

  // Element width default and accumulator format (Q16.24 in 40 bits)
  localparam int ELEM_BITS_DEF   = 16;
  localparam int ACC_BITS        = 40;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Result format: signed Q1.15, magnitude has 15 bits
  localparam int SIM_BITS = 16;
  localparam int Q_BITS   = SIM_BITS - 1;

  // Back-end arithmetic widths
  localparam int HALF_BITS = ACC_BITS / 2;           // partial-product operand
  localparam int MACC_BITS = 2 * ACC_BITS;           // partial-product accumulator
  localparam int PROD_BITS = 2 * (ACC_BITS - 1);     // norm product, norms < 2^39
  localparam int SQ_BITS   = 2 * ACC_BITS - 1;       // dot^2, |dot| <= 2^39
  localparam int LHS_SHIFT = 2 * Q_BITS;             // scale of dot^2 by 2^30
  localparam int WIDE_BITS = SQ_BITS + LHS_SHIFT;    // compare width
  localparam int BIT_IDX_BITS = $clog2(Q_BITS);

  // One finished vector pair, ready for the final ratio
  typedef struct packed {
    logic                degen;
    logic                dot_neg;
    logic [ACC_BITS-1:0] dot_mag;
    logic [ACC_BITS-1:0] norm_a;
    logic [ACC_BITS-1:0] norm_b;
  } job_t;

endpackage

// ----- sv/cosine_similarity_stream_core.sv -----
// ----------------------------------------------------------------------------
// cosine_similarity_stream_core
// Streaming cosine similarity of two fixed-point vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one element pair per
//   transfer, signed Q4.12, with last_i set on the final pair of a vector.
//   Pairs are taken one per cycle unless stalled; the front end multiplies
//   and accumulates into saturating 40-bit sums and needs no vector gap.
//   Output channel (out_valid_o / out_stall_i) carries one transfer per
//   vector: similarity in signed Q1.15 and a degenerate flag set when either
//   norm is zero (similarity then 0).
//   From the last pair's transfer to out_valid_o the result passes the
//   product stage, the queue, the back-end pickup, na*nb and dot^2 on one
//   shared 20x20 multiplier, the 15 result bits and the output register.
//   A degenerate vector skips the multiplier and the bit search and goes
//   from the back-end pickup straight to the output register.
//   Sustained rate: one pair per cycle while the back end keeps up with the
//   vectors; short vectors are limited by the back end, and the input
//   stalls when a last pair finds the job queue full.
//   A stalled output holds its result; the back end waits with the next one
//   and the front end keeps accumulating until a last pair finds the queue full.
//   Reset clears the sums, queue and output valid.
// ----------------------------------------------------------------------------
module cosine_similarity_stream_core #(
  parameter int ELEM_BITS   = css_pkg::ELEM_BITS_DEF,
  parameter int QUEUE_DEPTH = css_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [ELEM_BITS-1:0] a_elem_i,
  input  logic signed [ELEM_BITS-1:0] b_elem_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [css_pkg::SIM_BITS-1:0] similarity_o,
  output logic                        degenerate_o
);
  import css_pkg::*;

  logic push, queue_full, pop, queue_empty;
  job_t push_job, pop_job;

  // Accumulating front end
  css_front #(
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .a_elem_i     (a_elem_i),
    .b_elem_i     (b_elem_i),
    .last_i       (last_i),
    .push_o       (push),
    .push_job_o   (push_job),
    .queue_full_i (queue_full)
  );

  // Job queue
  css_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (queue_full),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (queue_empty)
  );

  // Ratio back end
  css_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_empty_i  (queue_empty),
    .job_i        (pop_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .similarity_o (similarity_o),
    .degenerate_o (degenerate_o)
  );

endmodule

// ----- sv/css_front.sv -----
// ----------------------------------------------------------------------------
// css_front
// Takes element pairs, squares and multiplies them in one registered stage,
// then adds them into three saturating accumulators. On the last pair the
// sums are classified (zero norm or not) and pushed into the job queue.
// ----------------------------------------------------------------------------
module css_front #(
  parameter int ELEM_BITS = css_pkg::ELEM_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [ELEM_BITS-1:0] a_elem_i,
  input  logic signed [ELEM_BITS-1:0] b_elem_i,
  input  logic                        last_i,
  output logic                        push_o,
  output css_pkg::job_t               push_job_o,
  input  logic                        queue_full_i
);
  import css_pkg::*;

  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int EXT_W  = (PROD_W > ACC_BITS) ? PROD_W : ACC_BITS;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // Clamp a raw product into the accumulator range
  function automatic logic signed [ACC_BITS-1:0] clamp_prod(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [EXT_W-1:0] p_ext;
    logic signed [EXT_W-1:0] max_ext;
    logic signed [EXT_W-1:0] min_ext;
    p_ext   = EXT_W'(p);
    max_ext = EXT_W'(ACC_MAX);
    min_ext = EXT_W'(ACC_MIN);
    if (p_ext > max_ext) begin
      clamp_prod = ACC_MAX;
    end else if (p_ext < min_ext) begin
      clamp_prod = ACC_MIN;
    end else begin
      clamp_prod = p_ext[ACC_BITS-1:0];
    end
  endfunction

  // Saturating accumulate
  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] acc,
    input logic signed [ACC_BITS-1:0] p
  );
    logic signed [ACC_BITS:0] s;
    s = {acc[ACC_BITS-1], acc} + {p[ACC_BITS-1], p};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      sat_add = s[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = s[ACC_BITS-1:0];
    end
  endfunction

  logic                       s1_valid_q, s1_last_q;
  logic signed [ACC_BITS-1:0] pd_q, pa_q, pb_q;
  logic signed [ACC_BITS-1:0] dot_q, na_q, nb_q;
  logic signed [ACC_BITS-1:0] dot_d, na_d, nb_d;
  logic signed [PROD_W-1:0]   prod_ab, prod_aa, prod_bb;
  logic                       advance;
  logic                       s1_fire;

  // Hold the product stage only when a last pair finds the queue full
  assign advance    = !(s1_valid_q && s1_last_q && queue_full_i);
  assign in_stall_o = !advance;
  assign s1_fire    = s1_valid_q && advance;

  assign prod_ab = a_elem_i * b_elem_i;
  assign prod_aa = a_elem_i * a_elem_i;
  assign prod_bb = b_elem_i * b_elem_i;

  // Product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s1_last_q  <= last_i;
    end
  end

  // Product stage payload
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      pd_q <= clamp_prod(prod_ab);
      pa_q <= clamp_prod(prod_aa);
      pb_q <= clamp_prod(prod_bb);
    end
  end

  // Sums including the pair in the product stage
  assign dot_d = sat_add(dot_q, pd_q);
  assign na_d  = sat_add(na_q, pa_q);
  assign nb_d  = sat_add(nb_q, pb_q);

  // Accumulators, cleared after the last pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
      end else begin
        dot_q <= dot_d;
        na_q  <= na_d;
        nb_q  <= nb_d;
      end
    end
  end

  // Classify the finished pair
  assign push_o             = s1_fire && s1_last_q;
  assign push_job_o.degen   = na_d[ACC_BITS-1] || (na_d == '0) ||
                              nb_d[ACC_BITS-1] || (nb_d == '0);
  assign push_job_o.dot_neg = dot_d[ACC_BITS-1];
  assign push_job_o.dot_mag = dot_d[ACC_BITS-1] ? (~dot_d + 1'b1) : dot_d;
  assign push_job_o.norm_a  = na_d;
  assign push_job_o.norm_b  = nb_d;

endmodule

// ----- sv/css_queue.sv -----
// ----------------------------------------------------------------------------
// css_queue
// Small register FIFO of finished jobs between front and back end.
// ----------------------------------------------------------------------------
module css_queue #(
  parameter int DEPTH = css_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  css_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output css_pkg::job_t pop_job_o,
  output logic          empty_o
);
  import css_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- sv/css_back.sv -----
// ----------------------------------------------------------------------------
// css_back
// Turns one job into a Q1.15 similarity. Forms na*nb and dot^2 with a shared
// 20x20 multiplier over four partial products each, then finds the largest q
// with q^2*na*nb <= dot^2*2^30 one result bit at a time (add, then compare).
// ----------------------------------------------------------------------------
module css_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_empty_i,
  input  css_pkg::job_t              job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [css_pkg::SIM_BITS-1:0] similarity_o,
  output logic                       degenerate_o
);
  import css_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SADD,
    ST_SCMP,
    ST_DONE
  } state_e;

  localparam logic [BIT_IDX_BITS-1:0] TOP_BIT = BIT_IDX_BITS'(Q_BITS - 1);

  state_e                  state_q;
  logic                    out_valid_q;
  logic [2:0]              mstep_q;     // [2] pass, [1:0] partial product
  logic [BIT_IDX_BITS-1:0] bit_q;

  job_t                    job_q;
  logic [2*HALF_BITS-1:0]  pp_q;
  logic [MACC_BITS-1:0]    macc_q;
  logic [PROD_BITS-1:0]    prod_q;
  logic [SQ_BITS-1:0]      sq_q;
  logic [WIDE_BITS-1:0]    p_q, r_q, s_q, cand_q;
  logic [Q_BITS-1:0]       q_q;
  logic signed [SIM_BITS-1:0] sim_q;
  logic                    degen_q;

  logic [ACC_BITS-1:0]     op_x, op_y;
  logic [HALF_BITS-1:0]    half_x, half_y;
  logic [MACC_BITS-1:0]    pp_shifted, macc_next;
  logic [WIDE_BITS-1:0]    lhs;
  logic                    accept_bit;
  logic                    out_free;
  logic signed [SIM_BITS-1:0] sim_next;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !job_empty_i;

  // Operand halves for the shared multiplier
  assign op_x   = mstep_q[2] ? job_q.dot_mag : job_q.norm_a;
  assign op_y   = mstep_q[2] ? job_q.dot_mag : job_q.norm_b;
  assign half_x = mstep_q[0] ? op_x[ACC_BITS-1:HALF_BITS] : op_x[HALF_BITS-1:0];
  assign half_y = mstep_q[1] ? op_y[ACC_BITS-1:HALF_BITS] : op_y[HALF_BITS-1:0];

  // Place the partial product by the weight of its halves
  always_comb begin
    pp_shifted = MACC_BITS'(pp_q);
    case (mstep_q[1:0]) inside
      2'd0:       pp_shifted = MACC_BITS'(pp_q);
      2'd1, 2'd2: pp_shifted = MACC_BITS'(pp_q) << HALF_BITS;
      default:    pp_shifted = MACC_BITS'(pp_q) << (2 * HALF_BITS);
    endcase
  end
  assign macc_next = macc_q + pp_shifted;

  // Bit trial: candidate q^2*prod against dot^2*2^30
  assign lhs        = {sq_q, {LHS_SHIFT{1'b0}}};
  assign accept_bit = (cand_q <= lhs);

  // Signed result from magnitude
  assign sim_next = job_q.degen ? '0 :
                    job_q.dot_neg ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

  // Sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mstep_q     <= '0;
      bit_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!job_empty_i) begin
            mstep_q <= '0;
            state_q <= job_i.degen ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 3'd7) begin
            bit_q   <= TOP_BIT;
            state_q <= ST_SADD;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_SADD: begin
          state_q <= ST_SCMP;
        end
        ST_SCMP: begin
          if (bit_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            bit_q   <= bit_q - 1'b1;
            state_q <= ST_SADD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_q  <= job_i;
          macc_q <= '0;
          q_q    <= '0;
        end
      end
      ST_MUL: begin
        pp_q <= half_x * half_y;
      end
      ST_ACC: begin
        if (mstep_q[1:0] == 2'd3) begin
          macc_q <= '0;
          if (mstep_q[2]) begin
            sq_q <= macc_next[SQ_BITS-1:0];
            p_q  <= '0;
            r_q  <= '0;
            s_q  <= WIDE_BITS'(prod_q) << (2 * (Q_BITS - 1));
          end else begin
            prod_q <= macc_next[PROD_BITS-1:0];
          end
        end else begin
          macc_q <= macc_next;
        end
      end
      ST_SADD: begin
        cand_q <= p_q + r_q + s_q;
      end
      ST_SCMP: begin
        // r tracks 2*q*2^b*prod, s tracks 2^(2b)*prod for the current bit b
        if (accept_bit) begin
          p_q        <= cand_q;
          r_q        <= (r_q >> 1) + s_q;
          q_q[bit_q] <= 1'b1;
        end else begin
          r_q <= r_q >> 1;
        end
        s_q <= s_q >> 2;
      end
      ST_DONE: begin
        if (out_free) begin
          sim_q   <= sim_next;
          degen_q <= job_q.degen;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign degenerate_o = degen_q;

endmodule
